// ===== design/box_blur_3x3_stream_core_defines.svh =====
// assertion macros for the 3x3 box blur stream core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BOX_BLUR_3X3_STREAM_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_STREAM_CORE_DEFINES_SVH

// clocked property, off while reset is asserted
`define BBLUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BBLUR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `BBLUR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/bblur_pkg.sv =====
// shared types, constants and a helper function of the 3x3 box blur core
// no dependencies
`timescale 1ns / 1ps

package bblur_pkg;

  // field widths
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned OUT_ROW_W  = 11;
  localparam int unsigned OUT_COL_W  = 11;
  localparam int unsigned OUT_CH_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_CH_W   = 3;

  // filter geometry and arithmetic
  localparam int unsigned KERNEL_DIM  = 3;
  localparam int unsigned QUOT_W      = 5;   // floor(255/9) = 28
  localparam int unsigned SUM_W       = 8;   // nine taps of at most 28
  localparam int unsigned PROD_W      = 14;
  localparam int unsigned RECIP9_MUL  = 57;  // 57/512 slightly above 1/9
  localparam int unsigned RECIP9_SHIFT = 9;
  localparam logic [PIXEL_W-1:0] BORDER_VALUE = 8'd255;

  // register values after reset
  localparam int unsigned WIDTH_RESET    = 640;
  localparam int unsigned HEIGHT_RESET   = 480;
  localparam int unsigned CHANNELS_RESET = 3;

  // bit positions of the result kinds one sample can cause, in output order
  localparam int unsigned RES_INNER    = 0;  // (r-1, c-1)
  localparam int unsigned RES_EDGE     = 1;  // (r-1, c) at the last column
  localparam int unsigned RES_LAST_ROW = 2;  // (r, c) on the last row
  localparam int unsigned RES_KINDS    = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  // one result item
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_CH_W-1:0]  channel;
    logic [PIXEL_W-1:0]   value;
    logic                 last_of_item;
    logic                 last_of_image;
  } res_t;

  // floor(p/9) for 8-bit p by reciprocal multiply
  function automatic logic [QUOT_W-1:0] div9(input logic [PIXEL_W-1:0] p);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(p) * PROD_W'(RECIP9_MUL);
    return prod[RECIP9_SHIFT +: QUOT_W];
  endfunction

endpackage

// ===== design/bblur_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module bblur_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/bblur_cfg.sv =====
// configuration registers with clamping to the supported image size
// depends on bblur_pkg
`timescale 1ns / 1ps

module bblur_cfg #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_HEIGHT   = 2048,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned DimWW        = $clog2(MAX_WIDTH + 1),
  parameter int unsigned DimHW        = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [DimWW-1:0]                  width_o,
  output logic [DimHW-1:0]                  height_o,
  output logic [bblur_pkg::CFG_CH_W-1:0]    chans_o,
  output logic                              restart_o
);

  import bblur_pkg::*;

  localparam int unsigned WidthRst  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int unsigned HeightRst = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
  localparam int unsigned ChansRst  =
    (CHANNELS_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS_RESET;

  logic [DimWW-1:0]    width_q, width_d;
  logic [DimHW-1:0]    height_q, height_d;
  logic [CFG_CH_W-1:0] chans_q, chans_d;
  logic                wr_xfer;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign wr_xfer     = cfg_valid_i && cfg_ready_o;
  assign restart_o   = wr_xfer;

  // register decode
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    chans_d  = chans_q;
    if (wr_xfer) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          width_d = DimWW'(clamp_dim(32'(cfg_data_i), MAX_WIDTH));
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = DimHW'(clamp_dim(32'(cfg_data_i), MAX_HEIGHT));
        end
        CFG_CHANNEL_COUNT: begin
          chans_d = CFG_CH_W'(clamp_dim(32'(cfg_data_i[CFG_CH_W-1:0]), MAX_CHANNELS));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimWW'(WidthRst);
      height_q <= DimHW'(HeightRst);
      chans_q  <= CFG_CH_W'(ChansRst);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      chans_q  <= chans_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;
  assign chans_o  = chans_q;

endmodule

// ===== design/bblur_scan.sv =====
// raster position counters and line store address of the next input sample
// depends on bblur_pkg
`timescale 1ns / 1ps

module bblur_scan #(
  parameter int unsigned RowW  = 11,
  parameter int unsigned ColW  = 11,
  parameter int unsigned ChW   = 2,
  parameter int unsigned AddrW = 13,
  parameter int unsigned DimWW = 12,
  parameter int unsigned DimHW = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           restart_i,
  input  logic [DimWW-1:0]               width_i,
  input  logic [DimHW-1:0]               height_i,
  input  logic [bblur_pkg::CFG_CH_W-1:0] chans_i,
  output logic [RowW-1:0]                row_o,
  output logic [ColW-1:0]                col_o,
  output logic [ChW-1:0]                 ch_o,
  output logic [AddrW-1:0]               addr_o
);

  import bblur_pkg::*;

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ChW-1:0]   ch_q, ch_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             ch_last, col_last, row_last;

  assign ch_last  = CFG_CH_W'(ch_q) == chans_i - 1'b1;
  assign col_last = col_q == ColW'(width_i - 1'b1);
  assign row_last = row_q == RowW'(height_i - 1'b1);

  // channel, then column, then row; the address restarts with each row
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    ch_d   = ch_q;
    addr_d = addr_q;
    if (restart_i) begin
      row_d  = '0;
      col_d  = '0;
      ch_d   = '0;
      addr_d = '0;
    end else if (adv_i) begin
      addr_d = addr_q + 1'b1;
      if (ch_last) begin
        ch_d = '0;
        if (col_last) begin
          col_d  = '0;
          addr_d = '0;
          row_d  = row_last ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        ch_d = ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ch_q   <= '0;
      addr_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      ch_q   <= ch_d;
      addr_q <= addr_d;
    end
  end

  assign row_o  = row_q;
  assign col_o  = col_q;
  assign ch_o   = ch_q;
  assign addr_o = addr_q;

endmodule

// ===== design/bblur_win.sv =====
// per-channel two-column window of tap quotients and the 3x3 tap sum
// depends on bblur_pkg
`timescale 1ns / 1ps

module bblur_win #(
  parameter int unsigned ChW = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [ChW-1:0]                ch_i,
  input  logic [bblur_pkg::PIXEL_W-1:0] older_i,
  input  logic [bblur_pkg::PIXEL_W-1:0] prev_i,
  input  logic [bblur_pkg::PIXEL_W-1:0] pixel_i,
  output logic [bblur_pkg::SUM_W-1:0]   sum_o
);

  import bblur_pkg::*;

  localparam int unsigned NumCh = 2 ** ChW;
  localparam int unsigned WinCols = KERNEL_DIM - 1;

  logic [QUOT_W-1:0] win_q [WinCols][KERNEL_DIM][NumCh];
  logic [QUOT_W-1:0] new_col [KERNEL_DIM];
  logic [SUM_W-1:0]  tap_sum;

  // quotients of the newest column, top row first
  always_comb begin
    new_col[0] = div9(older_i);
    new_col[1] = div9(prev_i);
    new_col[2] = div9(pixel_i);
  end

  // sum of the nine quotients of this channel
  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < KERNEL_DIM; i++) begin
      tap_sum = tap_sum + SUM_W'(new_col[i]) + SUM_W'(win_q[0][i][ch_i])
              + SUM_W'(win_q[1][i][ch_i]);
    end
  end

  // window shift for the channel of the sample that leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WinCols; j++) begin
        for (int i = 0; i < KERNEL_DIM; i++) begin
          for (int k = 0; k < NumCh; k++) begin
            win_q[j][i][k] <= '0;
          end
        end
      end
    end else if (shift_i) begin
      for (int i = 0; i < KERNEL_DIM; i++) begin
        win_q[0][i][ch_i] <= win_q[1][i][ch_i];
        win_q[1][i][ch_i] <= new_col[i];
      end
    end
  end

  assign sum_o = tap_sum;

endmodule

// ===== design/bblur_emit.sv =====
// result sequencer: up to three results per sample into one output register
// depends on bblur_pkg
`timescale 1ns / 1ps

module bblur_emit #(
  parameter int unsigned RowW  = 11,
  parameter int unsigned ColW  = 11,
  parameter int unsigned ChW   = 2,
  parameter int unsigned DimWW = 12,
  parameter int unsigned DimHW = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           busy_i,
  input  logic [RowW-1:0]                row_i,
  input  logic [ColW-1:0]                col_i,
  input  logic [ChW-1:0]                 ch_i,
  input  logic [DimWW-1:0]               width_i,
  input  logic [DimHW-1:0]               height_i,
  input  logic [bblur_pkg::CFG_CH_W-1:0] chans_i,
  input  logic [bblur_pkg::SUM_W-1:0]    sum_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output bblur_pkg::res_t                res_o,
  output logic                           leave_o
);

  import bblur_pkg::*;

  logic [RES_KINDS-1:0] done_q, done_d;
  logic [RES_KINDS-1:0] kinds, pend, pick;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;
  logic                 out_ready, load, last_item;
  logic                 row_last, col_last, ch_last, inner;
  logic [RowW-1:0]      sel_row;
  logic [ColW-1:0]      sel_col;

  assign row_last = row_i == RowW'(height_i - 1'b1);
  assign col_last = col_i == ColW'(width_i - 1'b1);
  assign ch_last  = CFG_CH_W'(ch_i) == chans_i - 1'b1;
  assign inner    = (row_i >= RowW'(2)) && (col_i >= ColW'(2));

  // which results this sample causes
  always_comb begin
    kinds               = '0;
    kinds[RES_INNER]    = (row_i != '0) && (col_i != '0);
    kinds[RES_EDGE]     = (row_i != '0) && col_last;
    kinds[RES_LAST_ROW] = row_last;
  end

  // oldest result still owed goes first
  assign pend      = busy_i ? (kinds & ~done_q) : '0;
  assign pick      = pend & (~pend + 1'b1);
  assign last_item = (pend & ~pick) == '0;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign load      = (pend != '0) && out_ready;
  assign leave_o   = busy_i && ((pend == '0) || (load && last_item));

  // fields of the picked result
  always_comb begin
    sel_row = row_i;
    sel_col = col_i;
    res_d.value = BORDER_VALUE;
    if (pick[RES_INNER]) begin
      sel_row = row_i - 1'b1;
      sel_col = col_i - 1'b1;
      res_d.value = inner ? sum_i : BORDER_VALUE;
    end else if (pick[RES_EDGE]) begin
      sel_row = row_i - 1'b1;
    end
    res_d.row           = OUT_ROW_W'(sel_row);
    res_d.col           = OUT_COL_W'(sel_col);
    res_d.channel       = OUT_CH_W'(ch_i);
    res_d.last_of_item  = last_item;
    res_d.last_of_image = (sel_row == RowW'(height_i - 1'b1))
                       && (sel_col == ColW'(width_i - 1'b1)) && ch_last;
  end

  // progress through the results of the held sample
  always_comb begin
    done_d = done_q;
    if (leave_o) begin
      done_d = '0;
    end else if (load) begin
      done_d = done_q | pick;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/box_blur_3x3_stream_core.sv =====
// 3x3 box blur on a raster, channel-interleaved sample stream; uses bblur_pkg
// a sample is held in the input register, its results in the single output register
// throughput: one sample per cycle when not stalled; a sample stays until all its
// results (up to three, row ends and last row) are loaded into the output register
// reset: counters at the image start, size 640x480x3, window zero; line stores not cleared
`timescale 1ns / 1ps
`include "box_blur_3x3_stream_core_defines.svh"

module box_blur_3x3_stream_core #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_HEIGHT   = 2048,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bblur_pkg::PIXEL_W-1:0]     pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bblur_pkg::OUT_ROW_W-1:0]   out_row_o,
  output logic [bblur_pkg::OUT_COL_W-1:0]   out_col_o,
  output logic [bblur_pkg::OUT_CH_W-1:0]    out_channel_o,
  output logic [bblur_pkg::PIXEL_W-1:0]     filtered_value_o,
  output logic                              last_of_item_o,
  output logic                              last_of_image_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import bblur_pkg::*;

  localparam int unsigned RowW       = $clog2(MAX_HEIGHT);
  localparam int unsigned ColW       = $clog2(MAX_WIDTH);
  localparam int unsigned ChW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned StoreDepth = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned DimWW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimHW      = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PairW      = 2 * PIXEL_W;

  logic [DimWW-1:0]    width;
  logic [DimHW-1:0]    height;
  logic [CFG_CH_W-1:0] chans;
  logic                restart;

  logic [RowW-1:0]  scan_row;
  logic [ColW-1:0]  scan_col;
  logic [ChW-1:0]   scan_ch;
  logic [AddrW-1:0] scan_addr;

  logic             in_xfer, s1_leave, fwd_d;
  logic             s1_valid_q, s1_valid_d;
  logic [PIXEL_W-1:0] s1_pixel_q;
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  logic [ChW-1:0]   s1_ch_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             fwd_q;
  logic [PairW-1:0] fwd_data_q;
  logic [PairW-1:0] store_rd, store_pair;
  logic [SUM_W-1:0] tap_sum;
  res_t             res;

  // configuration registers
  bblur_cfg #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .DimWW       (DimWW),
    .DimHW       (DimHW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .width_o    (width),
    .height_o   (height),
    .chans_o    (chans),
    .restart_o  (restart)
  );

  // position of the next input sample
  bblur_scan #(
    .RowW (RowW),
    .ColW (ColW),
    .ChW  (ChW),
    .AddrW(AddrW),
    .DimWW(DimWW),
    .DimHW(DimHW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (in_xfer),
    .restart_i(restart),
    .width_i  (width),
    .height_i (height),
    .chans_i  (chans),
    .row_o    (scan_row),
    .col_o    (scan_col),
    .ch_o     (scan_ch),
    .addr_o   (scan_addr)
  );

  // input register handshake: a new sample enters as the held one leaves
  assign in_stall_o = s1_valid_q && !s1_leave;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_leave) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // same line store address read while the held sample writes it: forward
  assign fwd_d = s1_valid_q && s1_leave && (scan_addr == s1_addr_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pixel_q <= pixel_value_i;
      s1_row_q   <= scan_row;
      s1_col_q   <= scan_col;
      s1_ch_q    <= scan_ch;
      s1_addr_q  <= scan_addr;
      fwd_q      <= fwd_d;
      fwd_data_q <= {store_pair[PIXEL_W-1:0], s1_pixel_q};
    end
  end

  // both line stores in one word: older row high, previous row low
  bblur_ram #(
    .Width(PairW),
    .Depth(StoreDepth),
    .AddrW(AddrW)
  ) u_lines (
    .clk_i    (clk_i),
    .wr_en_i  (s1_leave),
    .wr_addr_i(s1_addr_q),
    .wr_data_i({store_pair[PIXEL_W-1:0], s1_pixel_q}),
    .rd_en_i  (in_xfer),
    .rd_addr_i(scan_addr),
    .rd_data_o(store_rd)
  );

  assign store_pair = fwd_q ? fwd_data_q : store_rd;

  // column window and tap sum
  bblur_win #(
    .ChW(ChW)
  ) u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(s1_leave),
    .ch_i   (s1_ch_q),
    .older_i(store_pair[PairW-1:PIXEL_W]),
    .prev_i (store_pair[PIXEL_W-1:0]),
    .pixel_i(s1_pixel_q),
    .sum_o  (tap_sum)
  );

  // result sequencing and output register
  bblur_emit #(
    .RowW (RowW),
    .ColW (ColW),
    .ChW  (ChW),
    .DimWW(DimWW),
    .DimHW(DimHW)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_i     (s1_valid_q),
    .row_i      (s1_row_q),
    .col_i      (s1_col_q),
    .ch_i       (s1_ch_q),
    .width_i    (width),
    .height_i   (height),
    .chans_i    (chans),
    .sum_i      (tap_sum),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (res),
    .leave_o    (s1_leave)
  );

  assign out_row_o        = res.row;
  assign out_col_o        = res.col;
  assign out_channel_o    = res.channel;
  assign filtered_value_o = res.value;
  assign last_of_item_o   = res.last_of_item;
  assign last_of_image_o  = res.last_of_image;

  // checks
  `BBLUR_ASSERT_IMPLIES(a_image_end_ends_item, out_valid_o && last_of_image_o, last_of_item_o, "last of image without last of item")
  `BBLUR_ASSERT_IMPLIES(a_inner_sum_range, out_valid_o && (filtered_value_o != BORDER_VALUE), filtered_value_o <= 8'd252, "filtered value above nine maximal taps")
  `BBLUR_ASSERT(a_col_in_range, scan_col < width, "column counter beyond image width")
  `BBLUR_ASSERT(a_ch_in_range, CFG_CH_W'(scan_ch) < chans, "channel counter beyond channel count")

endmodule
